// ===== rtl/bps_pkg.sv =====
package bps_pkg;

  localparam int unsigned LaDepth = 4;
  localparam int unsigned CntW = $clog2(LaDepth + 1);
  localparam int unsigned QDepth = 2;

  localparam logic [2:0] DgmReset = 3'd3;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_FIXED    = 3'd1,
    KIND_LETTER   = 3'd2,
    KIND_DIGIT    = 3'd3,
    KIND_NEWLINE  = 3'd4,
    KIND_PUNCT    = 3'd5,
    KIND_PUNCT_NL = 3'd6,
    KIND_SPACE    = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    CLS_NL  = 3'd0,
    CLS_SP  = 3'd1,
    CLS_DIG = 3'd2,
    CLS_LET = 3'd3,
    CLS_PUN = 3'd4
  } cls_e;

  // byte plus its precomputed attributes
  typedef struct packed {
    logic [7:0] data;
    cls_e       cls;
    logic       apos;
    logic       space;
    logic       fix1;
    logic       is_r;
    logic       is_v;
    logic       is_l;
    logic       is_e;
    logic [1:0] need;
  } lab_t;

  typedef struct packed {
    lab_t lb;
    logic eot;
  } qent_t;

  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic            flushing;
    kind_e           kind;
    logic [1:0]      swallow;
  } bstat_t;

  function automatic lab_t classify(logic [7:0] b);
    lab_t       r;
    logic [7:0] fb;
    fb = (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
    r.data = b;
    if (b == 8'h0A || b == 8'h0D) begin
      r.cls = CLS_NL;
    end else if (b == 8'h20 || b == 8'h09) begin
      r.cls = CLS_SP;
    end else if (b >= 8'h30 && b <= 8'h39) begin
      r.cls = CLS_DIG;
    end else if ((fb >= 8'h61 && fb <= 8'h7A) || b >= 8'h80) begin
      r.cls = CLS_LET;
    end else begin
      r.cls = CLS_PUN;
    end
    r.apos  = (b == 8'h27);
    r.space = (b == 8'h20);
    r.fix1  = (fb == 8'h73) || (fb == 8'h74) || (fb == 8'h6D) || (fb == 8'h64);
    r.is_r  = (fb == 8'h72);
    r.is_v  = (fb == 8'h76);
    r.is_l  = (fb == 8'h6C);
    r.is_e  = (fb == 8'h65);
    if (b < 8'h80) begin
      r.need = 2'd0;
    end else if (b < 8'hE0) begin
      r.need = 2'd1;
    end else if (b < 8'hF0) begin
      r.need = 2'd2;
    end else begin
      r.need = 2'd3;
    end
    return r;
  endfunction

endpackage

// ===== rtl/bps_front.sv =====
module bps_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    text_byte_i,
  input  logic          end_of_text_i,
  output logic          head_valid_o,
  output bps_pkg::qent_t head_o,
  input  logic          pop_i
);
  import bps_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned FillW = $clog2(QDepth + 1);

  qent_t            mem_q [QDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             push;
  logic             pop;

  assign in_stall_o   = (fill_q == FillW'(QDepth));
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (fill_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? PtrW'((32'(wr_ptr_q) + 1) % QDepth) : wr_ptr_q;
    rd_ptr_d = pop ? PtrW'((32'(rd_ptr_q) + 1) % QDepth) : rd_ptr_q;
    fill_d   = fill_q + FillW'(push) - FillW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{lb: classify(text_byte_i), eot: end_of_text_i};
    end
  end

endmodule

// ===== rtl/bps_back.sv =====
module bps_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  bps_pkg::qent_t head_i,
  output logic           pop_o,
  input  logic [2:0]     dgm_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           piece_start_o,
  output logic           last_byte_o,
  output bps_pkg::bstat_t status_o
);
  import bps_pkg::*;

  lab_t            hb_q [LaDepth];
  lab_t            hb_d [LaDepth];
  lab_t            win  [LaDepth];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            end_q, end_d;
  kind_e           kind_q, kind_d;
  logic [2:0]      dc_q, dc_d;
  logic [1:0]      sw_q, sw_d;

  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic            start_q;
  logic            last_q;

  logic            take;
  logic [CntW-1:0] wcnt;
  logic [CntW-1:0] la;
  logic            wend;
  logic            slot_free;
  logic            ok;
  logic            cont;
  logic            lead;
  logic            start;
  logic            fire;
  logic            flush_done;
  logic [2:0]      lim;
  kind_e           kind_n;
  logic [2:0]      dc_n;
  logic [1:0]      sw_n;
  lab_t            b, n1, n2;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    take = head_valid_i && (cnt_q < CntW'(LaDepth)) && !end_q;
    wcnt = cnt_q + CntW'(take);
    wend = take ? head_i.eot : end_q;
    la   = wcnt - CntW'(1);
    for (int i = 0; i < LaDepth; i++) begin
      win[i] = (CntW'(i) < cnt_q) ? hb_q[i] : head_i.lb;
    end
    b   = win[0];
    n1  = win[1];
    n2  = win[2];
    lim = (dgm_i == 3'd0) ? 3'd1 : dgm_i;

    ok     = 1'b1;
    cont   = 1'b0;
    lead   = 1'b0;
    start  = 1'b0;
    kind_n = kind_q;
    dc_n   = dc_q;
    sw_n   = sw_q;

    if (sw_q != 2'd0) begin
      sw_n = sw_q - 2'd1;
    end else begin
      case (kind_q)
        KIND_LETTER:   cont = (b.cls == CLS_LET);
        KIND_DIGIT:    cont = (b.cls == CLS_DIG) && (dc_q < lim);
        KIND_NEWLINE:  cont = (b.cls == CLS_NL) || (b.cls == CLS_SP);
        KIND_PUNCT:    cont = (b.cls == CLS_PUN) || (b.cls == CLS_NL);
        KIND_PUNCT_NL: cont = (b.cls == CLS_NL);
        KIND_SPACE:    cont = (b.cls == CLS_SP);
        default:       cont = 1'b0;
      endcase
      if (cont) begin
        if (kind_q == KIND_LETTER) begin
          lead = 1'b1;
        end else if (kind_q == KIND_DIGIT) begin
          dc_n = dc_q + 3'd1;
        end else if (kind_q == KIND_PUNCT && b.cls == CLS_NL) begin
          kind_n = KIND_PUNCT_NL;
        end
      end else begin
        start = 1'b1;
        dc_n  = 3'd0;
        if (b.apos) begin
          kind_n = KIND_PUNCT;
          if (la == CntW'(0)) begin
            if (!wend) ok = 1'b0;
          end else if (n1.fix1) begin
            kind_n = KIND_FIXED;
            sw_n   = 2'd1;
          end else if (n1.is_r || n1.is_v || n1.is_l) begin
            if (la == CntW'(1)) begin
              if (!wend) ok = 1'b0;
            end else if ((n1.is_r && n2.is_e) || (n1.is_v && n2.is_e) ||
                         (n1.is_l && n2.is_l)) begin
              kind_n = KIND_FIXED;
              sw_n   = 2'd2;
            end
          end
        end else if (b.space) begin
          kind_n = KIND_SPACE;
          if (la == CntW'(0)) begin
            if (!wend) ok = 1'b0;
          end else if (n1.cls == CLS_LET) begin
            kind_n = KIND_LETTER;
          end else if (n1.cls == CLS_PUN) begin
            kind_n = KIND_PUNCT;
          end
        end else begin
          case (b.cls)
            CLS_LET: begin
              kind_n = KIND_LETTER;
              lead   = 1'b1;
            end
            CLS_DIG: begin
              kind_n = KIND_DIGIT;
              dc_n   = 3'd1;
            end
            CLS_NL:  kind_n = KIND_NEWLINE;
            CLS_PUN: kind_n = KIND_PUNCT;
            default: kind_n = KIND_SPACE;
          endcase
        end
      end
      if (lead && b.need != 2'd0) begin
        if (CntW'(b.need) > la) begin
          if (!wend) ok = 1'b0;
        end else begin
          sw_n = b.need;
        end
      end
    end

    fire       = ok && (wcnt != '0) && slot_free;
    flush_done = fire && wend && (wcnt == CntW'(1));

    for (int i = 0; i < LaDepth - 1; i++) begin
      hb_d[i] = fire ? win[i+1] : win[i];
    end
    hb_d[LaDepth-1] = win[LaDepth-1];

    cnt_d  = fire ? wcnt - CntW'(1) : wcnt;
    end_d  = wend;
    kind_d = kind_q;
    dc_d   = dc_q;
    sw_d   = sw_q;
    if (flush_done) begin
      end_d  = 1'b0;
      kind_d = KIND_NONE;
      dc_d   = 3'd0;
      sw_d   = 2'd0;
    end else if (fire) begin
      kind_d = kind_n;
      dc_d   = dc_n;
      sw_d   = sw_n;
    end
  end

  assign pop_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      end_q       <= 1'b0;
      kind_q      <= KIND_NONE;
      dc_q        <= 3'd0;
      sw_q        <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      end_q  <= end_d;
      kind_q <= kind_d;
      dc_q   <= dc_d;
      sw_q   <= sw_d;
      if (slot_free) begin
        out_valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hb_q <= hb_d;
    if (fire) begin
      out_byte_q <= b.data;
      start_q    <= start;
      last_q     <= wend && (wcnt == CntW'(1));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign piece_start_o = start_q;
  assign last_byte_o   = last_q;
  assign status_o      = '{cnt: cnt_q, flushing: end_q, kind: kind_q, swallow: sw_q};

endmodule

// ===== rtl/bpe_pretokenizer_splitter.sv =====
// Channel  Direction  Handshake             Payload
// in       input      in_valid_i/in_stall_o  text_byte_i, end_of_text_i
// out      output     out_valid_o/out_stall_i out_byte_o, piece_start_o, last_byte_o
// cfg      input      cfg_we_i              cfg_wdata_i (digit group limit)
//
// Sustains one byte per cycle unless the output stalls or a byte awaits lookahead; the
// back end takes and decides one byte per cycle. A byte waits for up to three following
// bytes (apostrophe contractions, a space ahead of a piece, a multi-byte lead).
// A request with end_of_text drains held bytes one per cycle unless the output stalls.
// Reset: run state empty, digit group limit 3. Input and output stall independently
// through a two-entry request queue and an output register.
module bpe_pretokenizer_splitter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       piece_start_o,
  output logic       last_byte_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i
);
  import bps_pkg::*;

  logic [2:0] dgm_val_q;
  logic       head_valid;
  qent_t      head;
  logic       pop;
  bstat_t     bstat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dgm_val_q <= DgmReset;
    end else if (cfg_we_i) begin
      dgm_val_q <= cfg_wdata_i;
    end
  end

  bps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .text_byte_i  (text_byte_i),
    .end_of_text_i(end_of_text_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  bps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .dgm_i        (dgm_val_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .piece_start_o(piece_start_o),
    .last_byte_o  (last_byte_o),
    .status_o     (bstat)
  );

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.cnt <= CntW'(LaDepth))
    else $error("lookahead overfilled");

  a_flush_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.flushing |-> bstat.cnt != '0)
    else $error("segment end pending with empty lookahead");

  a_swallow_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.swallow != 2'd0 |-> (bstat.kind == KIND_LETTER || bstat.kind == KIND_FIXED))
    else $error("swallow outside letter or contraction");

  a_pop_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid && bstat.cnt != CntW'(LaDepth) && !bstat.flushing)
    else $error("queue pop without room");

endmodule
